// File: hw/rtl/ftdt_pkg.sv
// Package for the float-to-decimal text converter.
// Constants, ASCII codes, controller state encoding, command and status structs.
// No dependencies.
package ftdt_pkg;

   localparam int MANT_W          = 24;
   localparam int EXP_W           = 8;
   localparam int INT_BITS        = 128;
   localparam int INT_CNT_W       = $clog2(INT_BITS + 2);
   localparam int BCD_DIGITS      = 39;
   localparam int BCD_W           = 4 * BCD_DIGITS;
   localparam int DIG_CNT_W       = $clog2(BCD_DIGITS + 1);
   localparam int FRAC_W          = 149;
   localparam int POS_W           = 6;
   localparam int CHAR_W          = 8;
   localparam int FRAC_DIGITS_DEF = 2;

   localparam logic [EXP_W-1:0] EXP_SPECIAL  = 8'hFF;
   localparam logic [EXP_W-1:0] EXP_SUBNORM  = 8'h00;
   localparam logic [EXP_W-1:0] EXP_BIAS_M1  = 8'd126;
   localparam logic [EXP_W-1:0] EXP_ALL_INT  = 8'd150;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_CONVERT = 7'b0000010,
      ST_SIGN    = 7'b0000100,
      ST_INT     = 7'b0001000,
      ST_POINT   = 7'b0010000,
      ST_FRAC    = 7'b0100000,
      ST_ERR     = 7'b1000000
   } state_type;

   typedef struct packed {
      logic load;
      logic dabble;
      logic emit_sign;
      logic emit_int;
      logic emit_point;
      logic emit_frac;
      logic emit_err;
   } cmd_type;

   typedef struct packed {
      logic special;
      logic dabble_done;
      logic int_last;
      logic frac_none;
      logic frac_last;
   } status_type;

endpackage

// File: hw/rtl/ftdt_ctrl.sv
// Controller state machine of the float-to-decimal text converter.
// Depends on ftdt_pkg; drives commands to ftdt_datapath, reads its status.
module ftdt_ctrl
   import ftdt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            priority if (status.special) begin
               state_in = ST_ERR;
            end else if (status.dabble_done) begin
               state_in = ST_SIGN;
            end else begin
               cmd.dabble = 1'b1;
            end
         end
         ST_SIGN: begin
            cmd.emit_sign = 1'b1;
            state_in      = ST_INT;
         end
         ST_INT: begin
            cmd.emit_int = 1'b1;
            if (status.int_last) begin
               state_in = ST_POINT;
            end
         end
         ST_POINT: begin
            cmd.emit_point = 1'b1;
            state_in       = status.frac_none ? ST_IDLE : ST_FRAC;
         end
         ST_FRAC: begin
            cmd.emit_frac = 1'b1;
            if (status.frac_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_ERR: begin
            cmd.emit_err = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// File: hw/rtl/ftdt_datapath.sv
// Datapath of the float-to-decimal text converter: bit-serial double dabble,
// fraction times-ten unit, character output register. Depends on ftdt_pkg.
module ftdt_datapath
   import ftdt_pkg::*;
#(
   parameter int FRAC_DIGITS = FRAC_DIGITS_DEF
)(
   input  logic              clock,
   input  logic              reset,
   input  logic [31:0]       req_value_bits,
   input  cmd_type           cmd,
   output status_type        status,
   output logic              rsp_valid,
   output logic [CHAR_W-1:0] rsp_char_code,
   output logic [POS_W-1:0]  rsp_position,
   output logic              rsp_last,
   output logic              rsp_error
);

   localparam int FCNT_W = $clog2(FRAC_DIGITS + 2);

   logic [EXP_W-1:0]     exp_field;
   logic [MANT_W-1:0]    mant_full;
   logic [EXP_W-1:0]     frac_shamt;

   logic [MANT_W-1:0]    mant_ff, mant_in;
   logic [INT_CNT_W-1:0] bits_ff, bits_in;
   logic [BCD_W-1:0]     bcd_ff, bcd_in;
   logic [BCD_W-1:0]     bcd_adj;
   logic [DIG_CNT_W-1:0] dig_ff, dig_in;
   logic                 started_ff, started_in;
   logic                 neg_ff, neg_in;
   logic                 special_ff, special_in;
   logic [FRAC_W-1:0]    frac_ff, frac_in;
   logic [FRAC_W+3:0]    frac_prod;
   logic [FCNT_W-1:0]    fcnt_ff, fcnt_in;
   logic [POS_W-1:0]     pos_ff, pos_in;

   logic                 valid_ff, valid_in;
   logic [CHAR_W-1:0]    char_ff, char_in;
   logic [POS_W-1:0]     opos_ff, opos_in;
   logic                 last_ff, last_in;
   logic                 err_ff, err_in;

   logic [3:0]           top_digit;
   logic                 show_digit;

   assign exp_field  = req_value_bits[30:23];
   assign mant_full  = {exp_field != EXP_SUBNORM, req_value_bits[22:0]};
   assign frac_shamt = (exp_field == EXP_SUBNORM) ? '0 : exp_field - 8'd1;

   always_comb begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
         bcd_adj[4*d +: 4] = (bcd_ff[4*d +: 4] > 4'd4) ? bcd_ff[4*d +: 4] + 4'd3
                                                       : bcd_ff[4*d +: 4];
      end
   end

   assign frac_prod  = {frac_ff, 3'b000} + {2'b00, frac_ff, 1'b0};
   assign top_digit  = bcd_ff[BCD_W-1 -: 4];
   assign show_digit = started_ff | (top_digit != 4'd0) | (dig_ff == DIG_CNT_W'(1));

   always_comb begin
      mant_in    = mant_ff;
      bits_in    = bits_ff;
      bcd_in     = bcd_ff;
      dig_in     = dig_ff;
      started_in = started_ff;
      neg_in     = neg_ff;
      special_in = special_ff;
      frac_in    = frac_ff;
      fcnt_in    = fcnt_ff;
      pos_in     = pos_ff;
      valid_in   = 1'b0;
      char_in    = char_ff;
      opos_in    = pos_ff;
      last_in    = 1'b0;
      err_in     = 1'b0;

      if (cmd.load) begin
         mant_in    = mant_full;
         bits_in    = (exp_field > EXP_BIAS_M1) ?
                      INT_CNT_W'(exp_field - EXP_BIAS_M1) : '0;
         bcd_in     = '0;
         dig_in     = DIG_CNT_W'(BCD_DIGITS);
         started_in = 1'b0;
         neg_in     = req_value_bits[31] & (mant_full != '0);
         special_in = (exp_field == EXP_SPECIAL);
         frac_in    = (exp_field < EXP_ALL_INT) ?
                      FRAC_W'({{(FRAC_W-MANT_W){1'b0}}, mant_full} << frac_shamt) : '0;
         fcnt_in    = FCNT_W'(FRAC_DIGITS);
         pos_in     = '0;
      end

      if (cmd.dabble) begin
         bcd_in  = {bcd_adj[BCD_W-2:0], mant_ff[MANT_W-1]};
         mant_in = {mant_ff[MANT_W-2:0], 1'b0};
         bits_in = bits_ff - 1'b1;
      end

      if (cmd.emit_sign && neg_ff) begin
         valid_in = 1'b1;
         char_in  = CHAR_MINUS;
         pos_in   = pos_ff + 1'b1;
      end

      if (cmd.emit_int) begin
         bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
         dig_in = dig_ff - 1'b1;
         if (show_digit) begin
            started_in = 1'b1;
            valid_in   = 1'b1;
            char_in    = CHAR_ZERO + CHAR_W'(top_digit);
            pos_in     = pos_ff + 1'b1;
         end
      end

      if (cmd.emit_point) begin
         valid_in = 1'b1;
         char_in  = CHAR_POINT;
         last_in  = (fcnt_ff == '0);
         pos_in   = pos_ff + 1'b1;
      end

      if (cmd.emit_frac) begin
         valid_in = 1'b1;
         char_in  = CHAR_ZERO + CHAR_W'(frac_prod[FRAC_W+3 -: 4]);
         last_in  = (fcnt_ff == FCNT_W'(1));
         frac_in  = frac_prod[FRAC_W-1:0];
         fcnt_in  = fcnt_ff - 1'b1;
         pos_in   = pos_ff + 1'b1;
      end

      if (cmd.emit_err) begin
         valid_in = 1'b1;
         char_in  = CHAR_NONE;
         opos_in  = '0;
         last_in  = 1'b1;
         err_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mant_ff    <= mant_in;
      bits_ff    <= bits_in;
      bcd_ff     <= bcd_in;
      dig_ff     <= dig_in;
      started_ff <= started_in;
      neg_ff     <= neg_in;
      special_ff <= special_in;
      frac_ff    <= frac_in;
      fcnt_ff    <= fcnt_in;
      pos_ff     <= pos_in;
      char_ff    <= char_in;
      opos_ff    <= opos_in;
      last_ff    <= last_in;
      err_ff     <= err_in;
   end

   assign status.special     = special_ff;
   assign status.dabble_done = (bits_ff == '0);
   assign status.int_last    = (dig_ff == DIG_CNT_W'(1));
   assign status.frac_none   = (fcnt_ff == '0);
   assign status.frac_last   = (fcnt_ff == FCNT_W'(1));

   assign rsp_valid     = valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_position  = opos_ff;
   assign rsp_last      = last_ff;
   assign rsp_error     = err_ff;

endmodule

// File: hw/rtl/float_to_decimal_text.sv
// Top level of the float-to-decimal text converter.
// Depends on ftdt_pkg, ftdt_ctrl and ftdt_datapath.
//
//   channel   ports                                 handshake
//   request   req_value_bits                        start & !busy
//   response  rsp_char_code rsp_position rsp_last   rsp_valid, one cycle, no stall
//             rsp_error
//
// One number goes through a load, a dabble step for each integer bit of the value (0..128,
// bit-serial double dabble over a 39-digit BCD register), a step to leave the conversion,
// a sign step, a scan over the 39 BCD digits, a point step and the FRAC_DIGITS fraction digits.
// Infinity or NaN go from the load to a single error character.
// Each character is registered and shown for one cycle.
// Synchronous active-high reset returns the controller to idle and drops rsp_valid.
module float_to_decimal_text
   import ftdt_pkg::*;
#(
   parameter int FRAC_DIGITS = FRAC_DIGITS_DEF
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [31:0]       req_value_bits,
   output logic              rsp_valid,
   output logic [CHAR_W-1:0] rsp_char_code,
   output logic [POS_W-1:0]  rsp_position,
   output logic              rsp_last,
   output logic              rsp_error
);

   cmd_type    cmd;
   status_type status;

   ftdt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   ftdt_datapath #(
      .FRAC_DIGITS (FRAC_DIGITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_value_bits (req_value_bits),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_char_code  (rsp_char_code),
      .rsp_position   (rsp_position),
      .rsp_last       (rsp_last),
      .rsp_error      (rsp_error)
   );

endmodule

// File: tb/float_to_decimal_text_checker.sv
// Checker for float_to_decimal_text: watches request and response traffic, predicts the text.
// Depends on ftdt_pkg; instantiated beside the block by float_to_decimal_text_tb.
module float_to_decimal_text_checker
   import ftdt_pkg::*;
#(
   parameter int FRAC_DIGITS = FRAC_DIGITS_DEF
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [31:0]       req_value_bits,
   input  logic              rsp_valid,
   input  logic [CHAR_W-1:0] rsp_char_code,
   input  logic [POS_W-1:0]  rsp_position,
   input  logic              rsp_last,
   input  logic              rsp_error,
   output int                failures,
   output int                outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_INT_DIGITS = 40;

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic [POS_W-1:0]  pos;
      logic              last;
      logic              err;
   } text_char_type;

   text_char_type expected_chars[$];
   int mismatch_count = 0;
   int char_backlog   = 0;

   assign failures    = mismatch_count;
   assign outstanding = char_backlog;

   function automatic void push_char(input logic [CHAR_W-1:0] code, input int pos,
                                     input int text_len, input logic err);
      text_char_type c;
      c.code = code;
      c.pos  = POS_W'(pos);
      c.last = (pos == text_len - 1);
      c.err  = err;
      expected_chars.push_back(c);
   endfunction

   // exact conversion: 128-bit integer part, fraction held in the low 160 bits
   function automatic void predict_text(input logic [31:0] bits);
      logic [EXP_W-1:0]  expo;
      logic [MANT_W-1:0] signif;
      logic [127:0]      whole;
      logic [163:0]      frac;
      logic [3:0]        digits[MAX_INT_DIGITS];
      logic              minus;
      int                e2;
      int                shift;
      int                nd;
      int                text_len;
      int                pos;
      expo   = bits[30:23];
      signif = {1'b0, bits[22:0]};
      if (expo == EXP_SPECIAL) begin
         push_char(CHAR_NONE, 0, 1, 1'b1);
         return;
      end
      if (expo == EXP_SUBNORM) begin
         e2 = -149;
      end else begin
         signif[MANT_W-1] = 1'b1;
         e2 = int'(expo) - 150;
      end
      frac = '0;
      if (e2 >= 0) begin
         whole = 128'(signif) << e2;
      end else begin
         shift = -e2;
         whole = (shift >= MANT_W) ? 128'd0 : 128'(signif >> shift);
         frac  = 164'(signif) << (160 - shift);
         frac[163:160] = 4'd0;
      end
      minus = bits[31] && (signif != '0);
      nd = 0;
      do begin
         digits[nd] = 4'(whole % 10);
         whole = whole / 10;
         nd++;
      end while (whole != 0 && nd < MAX_INT_DIGITS);
      text_len = (minus ? 1 : 0) + nd + 1 + FRAC_DIGITS;
      pos = 0;
      if (minus) begin
         push_char(CHAR_MINUS, pos, text_len, 1'b0);
         pos++;
      end
      for (int i = nd - 1; i >= 0; i--) begin
         push_char(CHAR_ZERO + CHAR_W'(digits[i]), pos, text_len, 1'b0);
         pos++;
      end
      push_char(CHAR_POINT, pos, text_len, 1'b0);
      pos++;
      for (int i = 0; i < FRAC_DIGITS; i++) begin
         frac = frac * 10;
         push_char(CHAR_ZERO + CHAR_W'(frac[163:160]), pos, text_len, 1'b0);
         frac[163:160] = 4'd0;
         pos++;
      end
   endfunction

   always @(posedge clock) begin
      text_char_type seen;
      text_char_type want;
      if (!reset && rsp_valid) begin
         seen = '{rsp_char_code, rsp_position, rsp_last, rsp_error};
         if (expected_chars.size() == 0) begin
            mismatch_count++;
            $display({"%0t: unexpected character: expected none,",
                      " actual char=%h pos=%0d last=%b error=%b"},
                     $time, seen.code, seen.pos, seen.last, seen.err);
         end else begin
            want = expected_chars.pop_front();
            if (seen !== want) begin
               mismatch_count++;
               $display({"%0t: mismatch: expected char=%h pos=%0d last=%b error=%b,",
                         " actual char=%h pos=%0d last=%b error=%b"},
                        $time, want.code, want.pos, want.last, want.err,
                        seen.code, seen.pos, seen.last, seen.err);
            end
         end
      end
      if (!reset && start && !busy)
         predict_text(req_value_bits);
      char_backlog = expected_chars.size();
   end

endmodule

// File: tb/float_to_decimal_text_tb.sv
// Testbench top for float_to_decimal_text: clock, reset, directed and random stimulus, verdict.
// Depends on ftdt_pkg, the block's RTL and float_to_decimal_text_checker.
module float_to_decimal_text_tb;
   import ftdt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 100;
   localparam int QUIET_TAIL   = 20;
   localparam int DRAIN_CYCLES = 200;
   localparam int CYCLE_LIMIT  = 250000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic [31:0]       req_value_bits = '0;
   logic              busy;
   logic              rsp_valid;
   logic [CHAR_W-1:0] rsp_char_code;
   logic [POS_W-1:0]  rsp_position;
   logic              rsp_last;
   logic              rsp_error;
   int                failures;
   int                outstanding;
   int                cycle_count = 0;

   logic [31:0] directed_values[] = '{
      32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h3F00_0000,
      32'h3E80_0000, 32'h3F7F_FFFF, 32'h0000_0001, 32'h807F_FFFF, 32'h0080_0000,
      32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
      32'hFFFF_FFFF, 32'h7F80_0001, 32'h4B7F_FFFF, 32'h4B80_0000, 32'h42C8_3333,
      32'h3DCC_CCCD, 32'h4120_0000, 32'h3C23_D70A, 32'hCCBE_BC20
   };

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   float_to_decimal_text #(.FRAC_DIGITS(FRAC_DIGITS_DEF)) DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value_bits (req_value_bits),
      .rsp_valid      (rsp_valid),
      .rsp_char_code  (rsp_char_code),
      .rsp_position   (rsp_position),
      .rsp_last       (rsp_last),
      .rsp_error      (rsp_error)
   );

   float_to_decimal_text_checker #(.FRAC_DIGITS(FRAC_DIGITS_DEF)) text_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value_bits (req_value_bits),
      .rsp_valid      (rsp_valid),
      .rsp_char_code  (rsp_char_code),
      .rsp_position   (rsp_position),
      .rsp_last       (rsp_last),
      .rsp_error      (rsp_error),
      .failures       (failures),
      .outstanding    (outstanding)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL float_to_decimal_text");
         $finish;
      end
   end

   // called at a falling edge; start stays high afterwards
   task automatic send_value(input logic [31:0] bits);
      start          <= 1'b1;
      req_value_bits <= bits;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic idle_burst();
      start <= 1'b0;
      repeat ($urandom_range(1, 15))
         @(negedge clock);
   endtask

   initial begin
      logic [31:0] value;
      repeat (12)
         @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_values[i]) begin
         send_value(directed_values[i]);
         if ($urandom_range(0, 3) == 0)
            idle_burst();
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         value = $urandom;
         case ($urandom_range(0, 9))
            0, 1, 2, 3: value[30:23] = 8'($urandom_range(100, 190));
            4:          value[30:23] = EXP_SUBNORM;
            5:          value[30:23] = EXP_SPECIAL;
            6:          value[30:23] = 8'($urandom_range(191, 254));
            7: begin
               value[30:23] = 8'($urandom_range(120, 152));
               value[22:0]  = value[22:0] & ~23'($urandom);
            end
            default: ;
         endcase
         send_value(value);
         if (i == RANDOM_ITEMS / 2) begin
            start <= 1'b0;
            while (outstanding != 0)
               @(negedge clock);
         end else if (i < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 2) == 0) begin
            idle_burst();
         end
      end

      start <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES)
         @(negedge clock);
      if (failures == 0 && outstanding == 0)
         $display("PASS float_to_decimal_text");
      else
         $display("FAIL float_to_decimal_text");
      $finish;
   end

endmodule
